### src/directional_ring_list_engine_assert.svh
// Assertion macros shared by the ring list engine RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef DIRECTIONAL_RING_LIST_ENGINE_ASSERT_SVH
`define DIRECTIONAL_RING_LIST_ENGINE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define DRLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define DRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/drle_pkg.sv
// Package for the ring list engine: widths, operation and status codes,
// cell control type and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int STEPS_W      = 32;
    localparam int COUNT_OUT_W  = 5;
    localparam int BITCNT_W     = $clog2(STEPS_W);

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_ROTATE = 2'd2,
        FUNC_PEEK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] fill;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ROTATE,
        ST_INSERT,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

### src/drle_req_if.sv
// Request channel of the ring list engine: valid/ready plus request fields.
// Depends on drle_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface drle_req_if;
    logic                                valid;
    logic                                ready;
    drle_pkg::func_t                     func;
    logic signed [drle_pkg::DATA_W-1:0]  value;
    logic                                direction;
    logic        [drle_pkg::STEPS_W-1:0] steps;

    modport source (output valid, func, value, direction, steps, input ready);
    modport sink   (input valid, func, value, direction, steps, output ready);
endinterface

`default_nettype wire

### src/drle_rsp_if.sv
// Result channel of the ring list engine: valid/ready plus result fields.
// Depends on drle_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface drle_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [drle_pkg::DATA_W-1:0]      result_value;
    drle_pkg::status_t                       status;
    logic        [drle_pkg::COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, result_value, status, entry_count, input ready);
    modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

`default_nettype wire

### src/drle_cell.sv
// One ring entry of the ring list engine cell chain.
// Depends on drle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drle_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                          clk,
    input  wire drle_pkg::cell_ctrl_t          ctrl,
    input  wire logic [CNT_W-1:0]              last_idx,
    input  wire logic [drle_pkg::DATA_W-1:0]   left_data,
    input  wire logic [drle_pkg::DATA_W-1:0]   right_data,
    input  wire logic [drle_pkg::DATA_W-1:0]   head_data,
    output logic      [drle_pkg::DATA_W-1:0]   data
);
    import drle_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              is_last;

    assign is_last = (last_idx == CNT_W'(INDEX));

    always_comb
    begin
        case (ctrl.op)
            CELL_INSERT: data_next = left_data;
            // wrap the head around to the tail entry
            CELL_ROTATE: data_next = is_last ? head_data : right_data;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### src/drle_mod.sv
// Restoring remainder unit: steps modulo the entry count, one bit a cycle.
// Depends on drle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drle_mod #(
    parameter int CNT_W = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [drle_pkg::STEPS_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]             divisor,
    output logic                              done,
    output logic      [CNT_W-1:0]             remainder
);
    import drle_pkg::*;

    localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(STEPS_W - 1);

    logic                run_reg,  run_next;
    logic                done_reg, done_next;
    logic [BITCNT_W-1:0] bit_reg,  bit_next;
    logic [STEPS_W-1:0]  dvd_reg,  dvd_next;
    logic [CNT_W-1:0]    rem_reg,  rem_next;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[STEPS_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            bit_next = '0;
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[STEPS_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            bit_next = bit_reg + 1'b1;
            if (bit_reg == LAST_BIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### src/directional_ring_list_engine.sv
// Ring list engine top level: sequencer, cell chain and remainder unit.
// Depends on drle_pkg, drle_req_if, drle_rsp_if, drle_cell, drle_mod and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "directional_ring_list_engine_assert.svh"

// Bounded ring of signed 32-bit values with a head. Entries live in a chain of
// CAPACITY cells in ring order: cell 0 is the head, cell k its k-th clockwise
// neighbour. Each cycle the chain can hold, shift one place toward the tail
// with a new value entering cell 0, or rotate one place toward the head within
// the live length (the head wraps into the last live cell). One request is
// worked at a time; the request port is ready whenever the sequencer is idle,
// and a finished beat sits in an output register so the next request can be
// taken while it waits. Work per request: a clockwise push into a non-empty
// ring rotates the old head to the tail, then inserts; other pushes, peeks,
// requests that find the ring empty and pushes that find it full go straight
// to the finish state; a pop rotates the head out and, when counter-clockwise
// on more than two entries, adds (count - 2) one-place rotations; a rotate
// runs a bit-serial remainder unit for steps mod count, then k (below CAPACITY)
// one-place rotations of the chain. Results that wait on a stalled sink
// hold the sequencer in its finish state until the output register frees up.
module directional_ring_list_engine #(
    parameter int CAPACITY = drle_pkg::CAPACITY_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    drle_req_if.sink  req,
    drle_rsp_if.source rsp
);
    import drle_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    // sequencer state
    seq_state_t          state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [CNT_W-1:0]    rot_cnt_reg, rot_cnt_next;
    logic [DATA_W-1:0]   result_reg,  result_next;
    status_t             status_reg,  status_next;
    logic [DATA_W-1:0]   value_reg,   value_next;
    logic                dir_reg,     dir_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]   out_value_reg;
    status_t                    out_status_reg;
    logic [COUNT_OUT_W-1:0]     out_count_reg;
    logic                       out_load;

    logic                req_fire;
    cell_ctrl_t          cell_ctrl;
    logic [CNT_W-1:0]    last_idx;
    logic [DATA_W-1:0]   cell_data  [CAPACITY];
    logic [DATA_W-1:0]   left_in    [CAPACITY];
    logic [DATA_W-1:0]   right_in   [CAPACITY];
    logic [DATA_W-1:0]   head;

    logic                mod_start;
    logic                mod_done;
    logic [CNT_W-1:0]    mod_rem;

    // checker helpers
    logic                push_ccw_fire;
    logic                pop_fire;
    logic [CNT_W-1:0]    count_up;
    logic [CNT_W-1:0]    count_dn;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign head      = cell_data[0];
    assign last_idx  = count_reg - ONE;

    // ---------------------------------------------------------------
    // Cell chain: cell 0 takes the fill value on insert, the tail cell
    // has no right neighbour (only the wrap path feeds it on rotate).
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = cell_ctrl.fill;
        end
        else
        begin : g_mid
            assign left_in[i] = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_in[i] = head;
        end
        else
        begin : g_inner
            assign right_in[i] = cell_data[i+1];
        end

        drle_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .last_idx   (last_idx),
            .left_data  (left_in[i]),
            .right_data (right_in[i]),
            .head_data  (head),
            .data       (cell_data[i])
        );
    end

    // Remainder unit for rotate: steps mod count.
    drle_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.steps),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // ---------------------------------------------------------------
    // Sequencer next state and chain control
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rot_cnt_next   = rot_cnt_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        dir_next       = dir_reg;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.fill = value_reg;
        mod_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    dir_next    = req.direction;
                    value_next  = req.value;
                    result_next = '0;
                    status_next = STATUS_OK;
                    state_next  = ST_FINISH;
                    case (req.func)
                        FUNC_PUSH:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (!req.direction && count_reg != '0)
                            begin
                                // clockwise: move old head to the tail first
                                cell_ctrl.op = CELL_ROTATE;
                                state_next   = ST_INSERT;
                            end
                            else
                            begin
                                cell_ctrl.op   = CELL_INSERT;
                                cell_ctrl.fill = req.value;
                                count_next     = count_reg + ONE;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // rotate the head to the tail and drop it
                                result_next  = head;
                                cell_ctrl.op = CELL_ROTATE;
                                count_next   = count_reg - ONE;
                                if (req.direction && count_reg > TWO)
                                begin
                                    // previous neighbour leads: rotate the
                                    // shorter ring by its length minus one
                                    rot_cnt_next = count_reg - TWO;
                                    state_next   = ST_ROTATE;
                                end
                            end
                        end
                        FUNC_ROTATE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = ST_MOD;
                            end
                        end
                        FUNC_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                result_next = head;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    if (mod_rem == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // counter-clockwise k equals clockwise count - k
                        rot_cnt_next = dir_reg ? (count_reg - mod_rem) : mod_rem;
                        state_next   = ST_ROTATE;
                    end
                end
            end

            ST_ROTATE:
            begin
                cell_ctrl.op = CELL_ROTATE;
                rot_cnt_next = rot_cnt_reg - ONE;
                if (rot_cnt_reg == ONE)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_INSERT:
            begin
                cell_ctrl.op   = CELL_INSERT;
                cell_ctrl.fill = value_reg;
                count_next     = count_reg + ONE;
                state_next     = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rot_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_cnt_reg   <= rot_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        dir_reg    <= dir_next;
        if (out_load)
        begin
            out_value_reg  <= result_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.entry_count  = out_count_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assign push_ccw_fire = req_fire && req.func == FUNC_PUSH && req.direction
                           && count_reg != CAP_CNT;
    assign pop_fire      = req_fire && req.func == FUNC_POP && count_reg != '0;
    assign count_up      = count_reg + ONE;
    assign count_dn      = count_reg - ONE;

    `DRLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_CNT, "entry count above capacity")
    `DRLE_ASSERT_NEXT(a_push_grows, push_ccw_fire, count_reg == $past(count_up), "no entry added")
    `DRLE_ASSERT_NEXT(a_pop_shrinks, pop_fire, count_reg == $past(count_dn), "no entry removed")
    `DRLE_ASSERT_NOW(a_rot_nonzero, state_reg == ST_ROTATE, rot_cnt_reg != '0, "zero rotations left")
    `DRLE_ASSERT_NOW(a_mod_range, mod_done, mod_rem < count_reg, "remainder out of range")

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the directional ring list engine.
// Depends on drle_pkg, drle_req_if, drle_rsp_if and directional_ring_list_engine.
`timescale 1ns / 1ps

import drle_pkg::*;

localparam int   RING_DEPTH = CAPACITY_DEF;
localparam logic DIR_CW     = 1'b0;
localparam logic DIR_CCW    = 1'b1;

typedef struct {
    logic signed [DATA_W-1:0]  result_value;
    status_t                   status;
    logic [COUNT_OUT_W-1:0]    entry_count;
} ring_result_t;

// Shadow copy of the ring in head-first order, plus the results it owes.
class ring_shadow;
    logic signed [DATA_W-1:0] ring[$];
    ring_result_t             pending_results[$];
    int                       error_count;
    int                       checked_count;
    int                       func_seen[4];
    int                       full_hits;
    int                       empty_hits;
    int                       max_fill;

    // Apply one accepted request to the shadow ring and queue its result.
    function void note_request(func_t f, logic signed [DATA_W-1:0] v, logic dir,
                               logic [STEPS_W-1:0] s);
        ring_result_t exp_res;
        int unsigned  n;
        int unsigned  k;
        exp_res.result_value = '0;
        exp_res.status       = STATUS_OK;
        n                    = ring.size();
        func_seen[int'(f)]++;
        if (f == FUNC_PUSH) begin
            if (n >= RING_DEPTH) begin
                exp_res.status = STATUS_FULL;
                full_hits++;
            end
            else begin
                // clockwise: old head ends up just before the new one
                if (dir == DIR_CW && n > 0)
                    ring.push_back(ring.pop_front());
                ring.push_front(v);
            end
        end
        else if (n == 0) begin
            exp_res.status = STATUS_EMPTY;
            empty_hits++;
        end
        else if (f == FUNC_POP) begin
            exp_res.result_value = ring.pop_front();
            if (dir == DIR_CCW && ring.size() > 1)
                ring.push_front(ring.pop_back());
        end
        else if (f == FUNC_ROTATE) begin
            k = s % n;
            for (int i = 0; i < k; i++) begin
                if (dir == DIR_CCW)
                    ring.push_front(ring.pop_back());
                else
                    ring.push_back(ring.pop_front());
            end
        end
        else begin
            exp_res.result_value = ring[0];
        end
        exp_res.entry_count = COUNT_OUT_W'(ring.size());
        if (ring.size() > max_fill)
            max_fill = ring.size();
        pending_results.push_back(exp_res);
    endfunction

    // Compare one result beat against the oldest owed result.
    function void check_result(logic signed [DATA_W-1:0] v, status_t st,
                               logic [COUNT_OUT_W-1:0] cnt);
        ring_result_t exp_res;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat value %0d status %0d count %0d",
                     $time, v, st, cnt);
            error_count++;
            return;
        end
        exp_res = pending_results.pop_front();
        checked_count++;
        if (v !== exp_res.result_value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, exp_res.result_value, v);
            error_count++;
        end
        if (st !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, st);
            error_count++;
        end
        if (cnt !== exp_res.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_res.entry_count, cnt);
            error_count++;
        end
    endfunction
endclass

module tb_top;

    logic clk;
    logic rst_n;

    drle_req_if req_ch ();
    drle_rsp_if rsp_ch ();

    directional_ring_list_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ring_shadow shadow = new;

    // Sender pacing: beats go out in bursts, with idle gaps between bursts.
    int burst_left;
    // Receiver stall pattern: a randomly picked mode, plus a tick counter that paces it.
    int stall_mode;
    int stall_tick;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hard limit on the run. A legal run of about 1130 beats, busy time, gaps
    // and stalls included, is meant to end before it.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check every accepted beat, then pick next cycle's ready.
    // Values read here are the ones that stood at the edge, since the block
    // updates its outputs through nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_result(rsp_ch.result_value, rsp_ch.status, rsp_ch.entry_count);
        stall_tick++;
        if (stall_tick % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;                          // no stalls at all
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));      // coin flip
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                default: rsp_ch.ready <= stall_tick[3];           // alternating on and off runs
            endcase
    end

    // Insert an idle gap when the current burst runs out. Drop valid only
    // when a gap really follows, so valid is never lowered and raised again
    // in the same step.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Drive one request beat, hold it until accepted, then record it.
    task automatic send_request(func_t f, logic signed [DATA_W-1:0] v, logic dir,
                                logic [STEPS_W-1:0] s);
        pace_sender();
        req_ch.valid     <= 1'b1;
        req_ch.func      <= f;
        req_ch.value     <= v;
        req_ch.direction <= dir;
        req_ch.steps     <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        shadow.note_request(f, v, dir, s);
    endtask

    // Hold the sender until every owed result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Pick steps: mostly small counts, some full-width and near-maximum,
    // some exact multiples of the capacity.
    function automatic logic [STEPS_W-1:0] pick_steps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 20);
        else if (r < 70)
            return $urandom;
        else if (r < 85)
            return 32'hFFFF_FFFF - $urandom_range(0, 20);
        else
            return RING_DEPTH * $urandom_range(0, 4);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int          push_weight;
        int          r;
        func_t       f;
        logic signed [DATA_W-1:0] seed_vals[4];

        seed_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};

        // Known values on every input from time zero.
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_PEEK;
        req_ch.value     = '0;
        req_ch.direction = DIR_CW;
        req_ch.steps     = '0;
        rsp_ch.ready     = 1'b0;
        burst_left       = 0;
        stall_mode       = 0;
        stall_tick       = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Empty ring: pop, peek and rotate in both directions report empty.
        send_request(FUNC_POP,    '0, DIR_CCW, '0);
        send_request(FUNC_PEEK,   '0, DIR_CW,  '0);
        send_request(FUNC_ROTATE, '0, DIR_CCW, 32'd5);
        send_request(FUNC_ROTATE, '0, DIR_CW,  32'hFFFF_FFFF);

        // Fill to capacity, alternating sides, extremes of value first.
        for (int i = 0; i < RING_DEPTH; i++)
            send_request(FUNC_PUSH, (i < 4) ? seed_vals[i] : $urandom,
                         (i % 2) ? DIR_CCW : DIR_CW, $urandom);

        // Full ring drops the push.
        send_request(FUNC_PUSH, 32'sh1234_5678, DIR_CW, '0);

        // Rotate by the widest count, by an exact multiple of the length,
        // and read the head.
        send_request(FUNC_ROTATE, '0, DIR_CW,  32'hFFFF_FFFF);
        send_request(FUNC_ROTATE, '0, DIR_CCW, RING_DEPTH);
        send_request(FUNC_PEEK,   '0, DIR_CCW, '0);

        // Pop from both sides.
        send_request(FUNC_POP, '0, DIR_CCW, '0);
        send_request(FUNC_POP, '0, DIR_CW,  '0);

        // Random part. The push weight shifts in phases so the ring swings
        // between empty and full many times.
        push_weight = 50;
        for (int i = 0; i < 1100; i++) begin
            if (i % 40 == 0)
                case ($urandom_range(0, 3))
                    0: push_weight = 15;
                    1: push_weight = 35;
                    2: push_weight = 50;
                    default: push_weight = 75;
                endcase
            // Stop sending once mid-run and let the block drain completely.
            if (i == 550)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < push_weight)
                f = FUNC_PUSH;
            else begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    f = FUNC_POP;
                else if (r < 8)
                    f = FUNC_ROTATE;
                else
                    f = FUNC_PEEK;
            end
            // value and steps ride along on every beat, used or not
            send_request(f, pick_value(), 1'($urandom_range(0, 1)), pick_steps());
        end

        // Release the channel, wait out every owed result, then allow for a
        // long rotate's worth of cycles in case a stray beat shows up.
        req_ch.valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("covered %0d push, %0d pop, %0d rotate, %0d peek; %0d results checked",
                 shadow.func_seen[FUNC_PUSH], shadow.func_seen[FUNC_POP],
                 shadow.func_seen[FUNC_ROTATE], shadow.func_seen[FUNC_PEEK],
                 shadow.checked_count);
        $display("full-ring pushes dropped: %0d, empty-ring requests: %0d, deepest fill: %0d",
                 shadow.full_hits, shadow.empty_hits, shadow.max_fill);
        if (shadow.error_count == 0 && shadow.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
